@@ sv/svna_pkg.sv @@
// svna_pkg: shared types, codes and defaults for the smooth vertex normal accumulator.
// Used by svna_ctrl, svna_dp, the top level and the testbench; depends on nothing.
package svna_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int COORD_BITS_DEF   = 16;
   localparam int SUM_BITS_DEF     = 24;
   localparam int IDX_W            = 12;
   localparam int FIELD_W          = 16;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TRI   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                    command;
      logic [IDX_W-1:0]           vert_idx;
      logic signed [FIELD_W-1:0]  pos_x;
      logic signed [FIELD_W-1:0]  pos_y;
      logic signed [FIELD_W-1:0]  pos_z;
      logic [IDX_W-1:0]           corner_a;
      logic [IDX_W-1:0]           corner_b;
      logic [IDX_W-1:0]           corner_c;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0]  normal_x;
      logic signed [FIELD_W-1:0]  normal_y;
      logic signed [FIELD_W-1:0]  normal_z;
      logic                       touched;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_LOAD, OP_POS_WR, OP_POS_RD, OP_EDGE, OP_MUL, OP_ABS,
      OP_SHR, OP_SHL, OP_ZERO_N, OP_SQ, OP_ROOT, OP_DIV_INIT, OP_DIV, OP_DIV_END,
      OP_ACC_RD, OP_ACC_WR, OP_RD_RD, OP_SUM_LOAD, OP_ZERO_OUT, OP_PUSH
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_TRI_RD, S_EDGE, S_CROSS, S_ABS, S_NORM, S_SQ,
      S_ROOT, S_DIV, S_ACC_RD, S_ACC_WR, S_RD_RD, S_RD_CHK, S_OUT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  sel;
      logic [2:0]  step;
   } ctrl_type;

   typedef struct packed {
      cmd_type  cmd;
      logic     idx_ok;
      logic     tri_ok;
      logic     touched;
      logic     zero;
      logic     too_big;
      logic     too_small;
      logic     clr_last;
   } status_type;

endpackage

@@ sv/svna_ram.sv @@
// svna_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module svna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/svna_ctrl.sv @@
// svna_ctrl: sequencer for load, triangle, read and clear commands.
// Depends on svna_pkg; drives the datapath through ctrl_type, reads status_type.
module svna_ctrl import svna_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output ctrl_type   ctrl
);
   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_push;
   state_type  done_state;

   assign can_push   = !rsp_valid_ff || !rsp_stall;
   assign done_state = (status.cmd == CMD_TRI) ? S_ACC_RD : S_OUT;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cnt_in = '0;
            unique case (status.cmd)
               CMD_LOAD:  state_in = S_IDLE;
               CMD_TRI:   state_in = status.tri_ok ? S_TRI_RD : S_IDLE;
               CMD_READ:  state_in = S_RD_RD;
               CMD_CLEAR: state_in = S_CLEAR;
               default:   state_in = S_IDLE;
            endcase
         end
         S_TRI_RD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               state_in = S_EDGE;
               cnt_in   = '0;
            end
         end
         S_EDGE: state_in = S_CROSS;
         S_CROSS: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd6) begin
               state_in = S_ABS;
               cnt_in   = '0;
            end
         end
         S_ABS: state_in = S_NORM;
         S_NORM: begin
            cnt_in = '0;
            k_in   = '0;
            if (status.zero) state_in = done_state;
            else if (!status.too_big && !status.too_small) state_in = S_SQ;
         end
         S_SQ: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               state_in = S_ROOT;
               cnt_in   = '0;
            end
         end
         S_ROOT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               state_in = S_DIV;
               cnt_in   = '0;
               k_in     = '0;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               cnt_in = '0;
               if (k_ff == 2'd2) begin
                  state_in = done_state;
                  k_in     = '0;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_ACC_RD: state_in = S_ACC_WR;
         S_ACC_WR: begin
            if (k_ff == 2'd2) begin
               state_in = S_IDLE;
               k_in     = '0;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_ACC_RD;
            end
         end
         S_RD_RD: state_in = S_RD_CHK;
         S_RD_CHK: state_in = (status.idx_ok && status.touched) ? S_ABS : S_OUT;
         S_OUT: begin
            if (can_push) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '{op: OP_NONE, sel: k_ff, step: cnt_ff[2:0]};
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_CLEAR:  ctrl.op = OP_CLR;
         S_IDLE:   ctrl.op = req_valid ? OP_LOAD : OP_NONE;
         S_DECODE: ctrl.op = (status.cmd == CMD_LOAD) ? OP_POS_WR : OP_NONE;
         S_TRI_RD: ctrl.op = OP_POS_RD;
         S_EDGE:   ctrl.op = OP_EDGE;
         S_CROSS:  ctrl.op = OP_MUL;
         S_ABS:    ctrl.op = OP_ABS;
         S_NORM: begin
            if (status.zero) ctrl.op = OP_ZERO_N;
            else if (status.too_big) ctrl.op = OP_SHR;
            else if (status.too_small) ctrl.op = OP_SHL;
            else ctrl.op = OP_NONE;
         end
         S_SQ:     ctrl.op = OP_SQ;
         S_ROOT:   ctrl.op = OP_ROOT;
         S_DIV: begin
            if (cnt_ff == 5'd0) ctrl.op = OP_DIV_INIT;
            else if (cnt_ff == 5'd16) ctrl.op = OP_DIV_END;
            else ctrl.op = OP_DIV;
         end
         S_ACC_RD: ctrl.op = OP_ACC_RD;
         S_ACC_WR: ctrl.op = OP_ACC_WR;
         S_RD_RD:  ctrl.op = OP_RD_RD;
         S_RD_CHK: ctrl.op = (status.idx_ok && status.touched) ? OP_SUM_LOAD : OP_ZERO_OUT;
         S_OUT:    ctrl.op = can_push ? OP_PUSH : OP_NONE;
         default:  ctrl.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.op == OP_PUSH) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

@@ sv/svna_dp.sv @@
// svna_dp: tables, cross product, normalize/isqrt/divide unit and accumulators.
// Depends on svna_pkg and svna_ram; sequenced by svna_ctrl.
module svna_dp import svna_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int SUM_BITS     = SUM_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  ctrl_type   ctrl,
   output status_type status,
   output rsp_type    rsp
);
   localparam int AW     = $clog2(MAX_VERTICES);
   localparam int C1     = COORD_BITS + 1;
   localparam int MUL_W  = (C1 > 31) ? C1 : 31;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CR_W   = 2 * COORD_BITS + 3;
   localparam int VEC_W  = (CR_W > SUM_BITS) ? CR_W : SUM_BITS;
   localparam int MAG_W  = (VEC_W > 31) ? VEC_W : 31;
   localparam int PW     = 3 * COORD_BITS;
   localparam int SW     = 3 * SUM_BITS;
   localparam int ROOT_W = 62;
   localparam int NUM_W  = 45;
   localparam int DEN_W  = 46;

   req_type                    req_ff;
   logic [PW-1:0]              pos_ff [3];
   logic signed [C1-1:0]       e1_ff [3];
   logic signed [C1-1:0]       e2_ff [3];
   logic signed [PROD_W-1:0]   prod_ff, hold_ff;
   logic signed [VEC_W-1:0]    vec_ff [3];
   logic                       neg_ff [3];
   logic [MAG_W-1:0]           mag_ff [3];
   logic [ROOT_W-1:0]          x_ff, r_ff, bit_ff;
   logic [NUM_W-1:0]           rem_ff;
   logic [DEN_W-1:0]           d_ff;
   logic [14:0]                q_ff;
   logic signed [FIELD_W-1:0]  n_ff [3];
   logic                       tflag_ff;
   rsp_type                    rsp_ff;
   logic [AW-1:0]              clr_ff;

   // table ports
   logic            pos_wr_en, pos_rd_en, sum_wr_en, sum_rd_en, tch_wr_en, tch_rd_en, tch_wr_data;
   logic [AW-1:0]   pos_wr_addr, pos_rd_addr, sum_addr, tch_wr_addr;
   logic [PW-1:0]   pos_wr_data, pos_rd_data;
   logic [SW-1:0]   sum_wr_data, sum_rd_data;
   logic            tch_rd_data;

   logic [IDX_W-1:0]          corner_acc, corner_pos;
   logic signed [MUL_W-1:0]   opa, opb;
   logic signed [PROD_W-1:0]  mul;
   logic signed [PROD_W:0]    dif;
   logic [MAG_W-1:0]          m01, mmax;
   logic [ROOT_W:0]           trial;
   logic                      root_ge, div_ge;
   logic [VEC_W-1:0]          uvec [3];
   logic signed [SUM_BITS:0]  sadd [3];
   logic signed [SUM_BITS-1:0] sat [3];

   assign status.cmd       = req_ff.command;
   assign status.idx_ok    = 32'(req_ff.vert_idx) < 32'(MAX_VERTICES);
   assign status.tri_ok    = (32'(req_ff.corner_a) < 32'(MAX_VERTICES))
                           && (32'(req_ff.corner_b) < 32'(MAX_VERTICES))
                           && (32'(req_ff.corner_c) < 32'(MAX_VERTICES));
   assign status.touched   = tch_rd_data;
   assign m01              = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign mmax             = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
   assign status.zero      = ~|mmax;
   assign status.too_big   = |mmax[MAG_W-1:30];
   assign status.too_small = ~|mmax[MAG_W-1:29];
   assign status.clr_last  = (clr_ff == AW'(MAX_VERTICES - 1));

   always_comb begin
      case (ctrl.sel)
         2'd0:    corner_acc = req_ff.corner_a;
         2'd1:    corner_acc = req_ff.corner_b;
         default: corner_acc = req_ff.corner_c;
      endcase
      case (ctrl.step[1:0])
         2'd0:    corner_pos = req_ff.corner_a;
         2'd1:    corner_pos = req_ff.corner_b;
         default: corner_pos = req_ff.corner_c;
      endcase
   end

   // shared multiplier: cross-product terms, then squares of the magnitudes
   always_comb begin
      opa = '0;
      opb = '0;
      if (ctrl.op == OP_MUL) begin
         case (ctrl.step)
            3'd0:    begin opa = MUL_W'(e2_ff[1]); opb = MUL_W'(e1_ff[2]); end
            3'd1:    begin opa = MUL_W'(e2_ff[2]); opb = MUL_W'(e1_ff[1]); end
            3'd2:    begin opa = MUL_W'(e2_ff[2]); opb = MUL_W'(e1_ff[0]); end
            3'd3:    begin opa = MUL_W'(e2_ff[0]); opb = MUL_W'(e1_ff[2]); end
            3'd4:    begin opa = MUL_W'(e2_ff[0]); opb = MUL_W'(e1_ff[1]); end
            default: begin opa = MUL_W'(e2_ff[1]); opb = MUL_W'(e1_ff[0]); end
         endcase
      end else begin
         case (ctrl.step[1:0])
            2'd0:    opa = MUL_W'($signed({1'b0, mag_ff[0][29:0]}));
            2'd1:    opa = MUL_W'($signed({1'b0, mag_ff[1][29:0]}));
            default: opa = MUL_W'($signed({1'b0, mag_ff[2][29:0]}));
         endcase
         opb = opa;
      end
   end

   assign mul     = opa * opb;
   assign dif     = (PROD_W+1)'(hold_ff) - (PROD_W+1)'(prod_ff);
   assign trial   = {1'b0, r_ff} + {1'b0, bit_ff};
   assign root_ge = {1'b0, x_ff} >= trial;
   assign div_ge  = {1'b0, rem_ff} >= d_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uvec[i] = vec_ff[i];
         sadd[i] = (SUM_BITS+1)'($signed(sum_rd_data[i*SUM_BITS +: SUM_BITS]))
                 + (SUM_BITS+1)'(n_ff[i]);
         if (sadd[i][SUM_BITS] != sadd[i][SUM_BITS-1])
            sat[i] = sadd[i][SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                       : {1'b0, {(SUM_BITS-1){1'b1}}};
         else
            sat[i] = sadd[i][SUM_BITS-1:0];
         sum_wr_data[i*SUM_BITS +: SUM_BITS] = tch_rd_data ? sat[i] : SUM_BITS'(n_ff[i]);
      end
   end

   always_comb begin
      pos_wr_en   = (ctrl.op == OP_POS_WR) && status.idx_ok;
      pos_wr_addr = AW'(req_ff.vert_idx);
      pos_wr_data = {COORD_BITS'(req_ff.pos_z), COORD_BITS'(req_ff.pos_y),
                     COORD_BITS'(req_ff.pos_x)};
      pos_rd_en   = (ctrl.op == OP_POS_RD) && (ctrl.step < 3'd3);
      pos_rd_addr = AW'(corner_pos);
      sum_wr_en   = (ctrl.op == OP_ACC_WR);
      sum_rd_en   = (ctrl.op == OP_ACC_RD) || (ctrl.op == OP_RD_RD);
      sum_addr    = (ctrl.op == OP_RD_RD) ? AW'(req_ff.vert_idx) : AW'(corner_acc);
      tch_rd_en   = sum_rd_en;
      tch_wr_en   = (ctrl.op == OP_ACC_WR) || (ctrl.op == OP_CLR);
      tch_wr_addr = (ctrl.op == OP_CLR) ? clr_ff : AW'(corner_acc);
      tch_wr_data = (ctrl.op == OP_ACC_WR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.op == OP_CLR) begin
         clr_ff <= status.clr_last ? '0 : clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LOAD: req_ff <= req;
         OP_POS_RD: begin
            if (ctrl.step != 3'd0) pos_ff[ctrl.step[1:0] - 2'd1] <= pos_rd_data;
         end
         OP_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= C1'($signed(pos_ff[1][i*COORD_BITS +: COORD_BITS]))
                         - C1'($signed(pos_ff[0][i*COORD_BITS +: COORD_BITS]));
               e2_ff[i] <= C1'($signed(pos_ff[2][i*COORD_BITS +: COORD_BITS]))
                         - C1'($signed(pos_ff[0][i*COORD_BITS +: COORD_BITS]));
            end
         end
         OP_MUL: begin
            if (ctrl.step < 3'd6) prod_ff <= mul;
            if (ctrl.step != 3'd0) begin
               if (ctrl.step[0]) hold_ff <= prod_ff;
               else vec_ff[ctrl.step[2:1] - 2'd1] <= VEC_W'(dif);
            end
         end
         OP_SUM_LOAD: begin
            for (int i = 0; i < 3; i++)
               vec_ff[i] <= VEC_W'($signed(sum_rd_data[i*SUM_BITS +: SUM_BITS]));
            tflag_ff <= 1'b1;
         end
         OP_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= vec_ff[i][VEC_W-1];
               mag_ff[i] <= MAG_W'(vec_ff[i][VEC_W-1] ? (~uvec[i] + 1'b1) : uvec[i]);
            end
         end
         OP_SHR: for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         OP_SHL: for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
         OP_ZERO_N: for (int i = 0; i < 3; i++) n_ff[i] <= '0;
         OP_ZERO_OUT: begin
            for (int i = 0; i < 3; i++) n_ff[i] <= '0;
            tflag_ff <= 1'b0;
         end
         OP_SQ: begin
            if (ctrl.step < 3'd3) prod_ff <= mul;
            if (ctrl.step == 3'd0) begin
               x_ff   <= '0;
               r_ff   <= '0;
               bit_ff <= ROOT_W'(1) << 60;
            end else begin
               x_ff <= x_ff + prod_ff[ROOT_W-1:0];
            end
         end
         OP_ROOT: begin
            if (root_ge) begin
               x_ff <= x_ff - trial[ROOT_W-1:0];
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_DIV_INIT: begin
            // rounded quotient: (mag * 2^14 + L/2) / L
            rem_ff <= NUM_W'({mag_ff[ctrl.sel][29:0], 14'd0}) + NUM_W'(r_ff[31:1]);
            d_ff   <= {r_ff[31:0], 14'd0};
            q_ff   <= '0;
         end
         OP_DIV: begin
            if (div_ge) rem_ff <= rem_ff - d_ff[NUM_W-1:0];
            q_ff <= {q_ff[13:0], div_ge};
            d_ff <= d_ff >> 1;
         end
         OP_DIV_END: begin
            n_ff[ctrl.sel] <= neg_ff[ctrl.sel] ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
         end
         OP_PUSH: rsp_ff <= '{normal_x: n_ff[0], normal_y: n_ff[1], normal_z: n_ff[2],
                               touched: tflag_ff};
         default: ;
      endcase
   end

   assign rsp = rsp_ff;

   svna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock, .wr_en(pos_wr_en), .wr_addr(pos_wr_addr), .wr_data(pos_wr_data),
      .rd_en(pos_rd_en), .rd_addr(pos_rd_addr), .rd_data(pos_rd_data)
   );

   svna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock, .wr_en(sum_wr_en), .wr_addr(sum_addr), .wr_data(sum_wr_data),
      .rd_en(sum_rd_en), .rd_addr(sum_addr), .rd_data(sum_rd_data)
   );

   svna_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_tch_ram (
      .clock, .wr_en(tch_wr_en), .wr_addr(tch_wr_addr), .wr_data(tch_wr_data),
      .rd_en(tch_rd_en), .rd_addr(sum_addr), .rd_data(tch_rd_data)
   );
endmodule

@@ sv/smooth_vertex_normal_accumulator_top.sv @@
// Top level of the smooth vertex normal accumulator: sequencer plus datapath.
// Depends on svna_pkg, svna_ctrl, svna_dp (and svna_ram below it).
//
//   channel  ports                          direction  beat
//   req      req_valid/req_stall/req        in         one command (req_type)
//   rsp      rsp_valid/rsp_stall/rsp        out        one read result (rsp_type)
//
// One command at a time. A triangle reads its corners and forms edges and the cross product;
// that vector, or a touched read's sum, then passes the serial normalize shift (one bit per
// cycle), the 31-step square root and one divider used three times (15 quotient steps).
// A zero vector skips root and divide; a load or an untouched read does none of this.
// Clear and reset: a sweep over all MAX_VERTICES entries of the touched table, no
// commands taken meanwhile. A held result stalls only the next read's final beat.
module smooth_vertex_normal_accumulator_top import svna_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int SUM_BITS     = SUM_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);
   ctrl_type   ctrl;
   status_type status;

   svna_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .status, .ctrl
   );

   svna_dp #(
      .MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)
   ) u_dp (
      .clock, .reset, .req, .ctrl, .status, .rsp
   );

   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.touched |-> rsp.normal_x == 0 && rsp.normal_y == 0
                                    && rsp.normal_z == 0)
      else $error("untouched result with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.normal_x <= 16384 && rsp.normal_x >= -16384
                 && rsp.normal_y <= 16384 && rsp.normal_y >= -16384
                 && rsp.normal_z <= 16384 && rsp.normal_z >= -16384)
      else $error("normal component out of unit range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while busy");
endmodule

@@ bench/smooth_vertex_normal_accumulator_top_tb.sv @@
// Testbench for smooth_vertex_normal_accumulator_top: directed and random command streams,
// with a built-in predictor of positions, normal sums and touched flags. Depends on svna_pkg.
`timescale 1ns / 1ps

module smooth_vertex_normal_accumulator_top_tb import svna_pkg::*; ();

   localparam int NVERT = MAX_VERTICES_DEF;
   localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS_DEF - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp;

   smooth_vertex_normal_accumulator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   always #5 clock = ~clock;

   // predictor state
   longint   vert_pos [NVERT][3];
   longint   normal_sum [NVERT][3];
   bit       touched_flag [NVERT];
   bit       loaded [NVERT];
   rsp_type  pending_normals [$];
   int       mismatches = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) <<< 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale a vector to Q1.14 unit length; zero stays zero
   function automatic void unit_normal(input longint v [3], output logic signed [15:0] n [3]);
      longint unsigned mag [3];
      longint unsigned m, len2, len, q;
      bit neg [3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) n[i] = '0;
         return;
      end
      while (m >= (longint'(1) <<< 30)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (longint'(1) <<< 29)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += mag[i] * mag[i];
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + len / 2) / len;
         n[i] = neg[i] ? -16'(q) : 16'(q);
      end
   endfunction

   function automatic longint clamp_sum(longint s);
      if (s > SUM_HI) return SUM_HI;
      if (s < SUM_LO) return SUM_LO;
      return s;
   endfunction

   task automatic accumulate_face(int a, int b, int c);
      longint e1 [3], e2 [3], cr [3];
      logic signed [15:0] n [3];
      int k [3];
      for (int i = 0; i < 3; i++) begin
         e1[i] = vert_pos[b][i] - vert_pos[a][i];
         e2[i] = vert_pos[c][i] - vert_pos[a][i];
      end
      cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
      cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
      cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
      unit_normal(cr, n);
      k[0] = a; k[1] = b; k[2] = c;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++)
            normal_sum[k[j]][i] = touched_flag[k[j]] ?
               clamp_sum(normal_sum[k[j]][i] + longint'(n[i])) : longint'(n[i]);
         touched_flag[k[j]] = 1;
      end
   endtask

   task automatic predict_command(req_type r);
      rsp_type e;
      logic signed [15:0] n [3];
      longint s [3];
      case (r.command)
         CMD_LOAD: begin
            vert_pos[r.vert_idx][0] = longint'(r.pos_x);
            vert_pos[r.vert_idx][1] = longint'(r.pos_y);
            vert_pos[r.vert_idx][2] = longint'(r.pos_z);
            loaded[r.vert_idx] = 1;
         end
         CMD_TRI: accumulate_face(int'(r.corner_a), int'(r.corner_b), int'(r.corner_c));
         CMD_CLEAR: foreach (touched_flag[i]) touched_flag[i] = 0;
         CMD_READ: begin
            e = '0;
            if (touched_flag[r.vert_idx]) begin
               for (int i = 0; i < 3; i++) s[i] = normal_sum[r.vert_idx][i];
               unit_normal(s, n);
               e.normal_x = n[0];
               e.normal_y = n[1];
               e.normal_z = n[2];
               e.touched = 1;
            end
            pending_normals = {pending_normals, e};
         end
      endcase
   endtask

   // one beat on the request channel, with a random gap ahead of it
   task automatic send_command(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req = r;
      do @(posedge clock); while (req_stall);
      predict_command(r);
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic req_type load_cmd(int idx, int x, int y, int z);
      req_type r;
      r = '0;
      r.command = CMD_LOAD;
      r.vert_idx = 12'(idx);
      r.pos_x = 16'(x); r.pos_y = 16'(y); r.pos_z = 16'(z);
      return r;
   endfunction

   function automatic req_type face_cmd(int a, int b, int c);
      req_type r;
      r = '0;
      r.command = CMD_TRI;
      r.corner_a = 12'(a); r.corner_b = 12'(b); r.corner_c = 12'(c);
      return r;
   endfunction

   function automatic req_type read_cmd(int idx);
      req_type r;
      r = '0;
      r.command = CMD_READ;
      r.vert_idx = 12'(idx);
      return r;
   endfunction

   function automatic req_type clear_cmd();
      req_type r;
      r = '0;
      r.command = CMD_CLEAR;
      return r;
   endfunction

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp);
         end else begin
            e = pending_normals.pop_front();
            if (rsp.normal_x !== e.normal_x || rsp.normal_y !== e.normal_y ||
                rsp.normal_z !== e.normal_z || rsp.touched !== e.touched) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal mismatch: expected %0d %0d %0d t%0b, got %0d %0d %0d t%0b",
                     e.normal_x, e.normal_y, e.normal_z, e.touched,
                     rsp.normal_x, rsp.normal_y, rsp.normal_z, rsp.touched);
            end
         end
      end
   end

   // extremes, axis normal, untouched read, degenerate face, clear
   task automatic test_directed();
      send_command(load_cmd(0, 0, 0, 0));
      send_command(load_cmd(1, 256, 0, 0));
      send_command(load_cmd(2, 0, 256, 0));
      send_command(load_cmd(4095, 32767, -32768, 32767));
      send_command(load_cmd(4094, -32768, 32767, -32768));
      send_command(read_cmd(0));
      send_command(face_cmd(0, 1, 2));
      send_command(read_cmd(0));
      send_command(read_cmd(4095));
      send_command(face_cmd(4095, 4094, 0));
      send_command(face_cmd(4094, 2, 4095));
      send_command(read_cmd(4095));
      send_command(read_cmd(4094));
      send_command(load_cmd(3, 100, -7, 55));
      send_command(face_cmd(3, 3, 3));
      send_command(read_cmd(3));
      send_command(face_cmd(1, 1, 2));
      send_command(read_cmd(1));
      send_command(clear_cmd());
      send_command(read_cmd(0));
      send_command(face_cmd(2, 0, 1));
      send_command(read_cmd(2));
   endtask

   // enough identical faces to drive the z sums of all three corners past their range
   task automatic test_saturation();
      send_command(clear_cmd());
      send_command(load_cmd(20, 0, 0, 0));
      send_command(load_cmd(21, 256, 0, 0));
      send_command(load_cmd(22, 0, 256, 0));
      repeat (520) send_command(face_cmd(20, 21, 22));
      send_command(read_cmd(20));
      send_command(face_cmd(20, 22, 21));
      send_command(read_cmd(20));
   endtask

   function automatic int pool_vertex();
      int v;
      v = $urandom_range(31);
      return (v < 16) ? v : 4080 + v - 16;
   endfunction

   task automatic test_random(int count);
      int sel, a, b, c, span;
      for (int i = 0; i < 32; i++) begin
         a = (i < 16) ? i : 4080 + i - 16;
         if (!loaded[a])
            send_command(load_cmd(a, $urandom_range(65535), $urandom_range(65535),
               $urandom_range(65535)));
      end
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 25) begin
            a = ($urandom_range(9) == 0) ? $urandom_range(4095) : pool_vertex();
            span = ($urandom_range(2) == 0) ? 600 : 32768;
            send_command(load_cmd(a, $urandom_range(2 * span - 1) - span,
               $urandom_range(2 * span - 1) - span, $urandom_range(2 * span - 1) - span));
         end else if (sel < 65) begin
            a = pool_vertex();
            b = pool_vertex();
            c = ($urandom_range(9) == 0) ? a : pool_vertex();
            send_command(face_cmd(a, b, c));
         end else if (sel < 96) begin
            send_command(read_cmd(($urandom_range(19) == 0) ? $urandom_range(4095)
               : pool_vertex()));
         end else begin
            send_command(clear_cmd());
         end
      end
   endtask

   task automatic drain();
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_idle_pct = 16;
      recv_idle_pct = 85;
      test_directed();
      test_saturation();
      test_random(30);
      send_idle_pct = 85;
      recv_idle_pct = 16;
      test_random(25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(30);
      drain();
      if (mismatches == 0 && pending_normals.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ smooth_vertex_normal_accumulator_top.f @@
sv/svna_pkg.sv
sv/svna_ram.sv
sv/svna_ctrl.sv
sv/svna_dp.sv
sv/smooth_vertex_normal_accumulator_top.sv
bench/smooth_vertex_normal_accumulator_top_tb.sv
